// ===== rtl/core/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg: shared types and constants of the ray/triangle intersection block
// Holds the beat formats of both channels, the configuration register
// indexes and the fixed-point constants used across the design.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FIELD_W    = 60;
  localparam int TAG_W      = 24;
  localparam int DIST_W     = 31;
  localparam int WEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DETERMINANT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE    = 1'd1;

  // The determinant carries 36 fraction bits; the threshold is in units of 2^-16.
  localparam int DET_SHIFT = 20;
  // Fraction bits of distance and weights.
  localparam int Q_FRAC    = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [DIST_W-1:0]   DIST_MAX   = 31'h7fffffff;

  typedef struct packed {
    logic [FIELD_W-1:0] ray_origin;
    logic [FIELD_W-1:0] ray_direction;
    logic [FIELD_W-1:0] corner_a;
    logic [FIELD_W-1:0] corner_b;
    logic [FIELD_W-1:0] corner_c;
    logic [FIELD_W-1:0] normal_a;
    logic [FIELD_W-1:0] normal_b;
    logic [FIELD_W-1:0] normal_c;
    logic [TAG_W-1:0]   tri_tag;
  } rti_in_t;

  typedef struct packed {
    logic                hit;
    logic [DIST_W-1:0]   distance;
    logic [WEIGHT_W-1:0] weight_a;
    logic [WEIGHT_W-1:0] weight_b;
    logic [WEIGHT_W-1:0] weight_c;
    logic [FIELD_W-1:0]  hit_normal;
    logic [TAG_W-1:0]    tag_out;
  } rti_out_t;

  // Fields that ride along the pipeline untouched until the normal blend.
  typedef struct packed {
    logic [FIELD_W-1:0] normal_a;
    logic [FIELD_W-1:0] normal_b;
    logic [FIELD_W-1:0] normal_c;
    logic [TAG_W-1:0]   tri_tag;
  } rti_side_t;

endpackage

// ===== rtl/core/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect: pipelined Moller-Trumbore ray/triangle test
// Takes one ray and one triangle per beat and returns hit flag, distance,
// barycentric weights and the blended normal of the hit point.
// ----------------------------------------------------------------------------
// The block takes one input beat per clock while in_stall is low and returns
// exactly one result beat for each, in order. The result passes through 43
// register stages: 9 stages compute edges, cross products, the four exact dot
// products (determinant, u, v, t numerators) and the hit tests, 31 stages form
// the quotients t/det, u/det and v/det one bit per stage in three parallel
// restoring dividers, and 3 stages finish the weights, blend the corner normals
// and register the result. Every stage holds its own valid bit; when out_stall
// is high the stages behind the result register keep filling their empty slots,
// so the input only stalls once the whole pipeline is full. The configuration
// registers may only be written while no beat is in flight.
// All arithmetic before the division is exact; the distance is truncated and
// saturated to unsigned Q15.16, and the normal is rounded half up and saturated.
module ray_triangle_intersect #(
  parameter int COORD_BITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rti_pkg::rti_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rti_pkg::rti_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [rti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rti_pkg::*;

  // Component and intermediate widths, all exact for the coordinate width.
  localparam int C   = COORD_BITS;
  localparam int EW  = C + 1;          // edge and offset components
  localparam int PMW = 2 * C + 1;      // products of the first cross product
  localparam int QMW = 2 * C + 2;      // products of the second cross product
  localparam int XW  = 2 * C + 3;      // cross product components
  localparam int LB  = (XW + 1) / 2;   // low split of a cross component
  localparam int HW  = XW - LB;
  localparam int PLW = EW + LB + 1;
  localparam int PHW = EW + HW;
  localparam int W   = 3 * C + 6;      // signed dot products
  localparam int DW  = 3 * C + 5;      // magnitudes in the dividers
  localparam int NW  = C + WEIGHT_W + 1;
  localparam int SW  = NW + 2;

  localparam int QW    = DIST_W;       // quotient bits per divider
  localparam int DIV_N = QW;

  // Stage indexes.
  localparam int S_SUB = 0;
  localparam int S_XM  = 1;
  localparam int S_XS  = 2;
  localparam int S_DM  = 3;
  localparam int S_DC  = 4;
  localparam int S_DS  = 5;
  localparam int S_NG  = 6;
  localparam int S_CK  = 7;
  localparam int S_DI  = 8;
  localparam int S_WA  = S_DI + DIV_N + 1;
  localparam int S_NM  = S_WA + 1;
  localparam int S_OUT = S_NM + 1;
  localparam int NS    = S_OUT + 1;

  localparam logic signed [SW-1:0] NHI = SW'((2 ** (C - 1)) - 1);
  localparam logic signed [SW-1:0] NLO = ~NHI;
  localparam logic signed [SW-1:0] RND = SW'(2 ** (Q_FRAC - 1));

  function automatic logic signed [C-1:0] comp(input logic [FIELD_W-1:0] v, input int k);
    logic [63:0] x;
    x = 64'(v);
    return $signed(x[k*C +: C]);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] min_det_r;
  logic [CFG_DATA_W-1:0] min_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_det_r  <= 16'd1;
      min_dist_r <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_DETERMINANT: min_det_r  <= cfg_wdata;
        CFG_MIN_DISTANCE:    min_dist_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or its beat moves on.
  // --------------------------------------------------------------------------
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  logic [NS-1:0] v_in;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign v_in     = {v_r[NS-2:0], in_valid};
  assign in_stall = !en[S_SUB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= v_in[i];
        end
      end
    end
  end

  // Normals and tag travel unchanged up to the normal blend.
  rti_side_t side_r [0:S_NM];

  always_ff @(posedge clk) begin
    if (en[S_SUB]) begin
      side_r[0] <= '{normal_a: in_data.normal_a, normal_b: in_data.normal_b,
                     normal_c: in_data.normal_c, tri_tag: in_data.tri_tag};
    end
    for (int i = 1; i <= S_NM; i++) begin
      if (en[i]) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: unpack, edges and origin offset.
  // --------------------------------------------------------------------------
  logic signed [C-1:0]  oc [3];
  logic signed [C-1:0]  dc [3];
  logic signed [C-1:0]  ac [3];
  logic signed [C-1:0]  bc [3];
  logic signed [C-1:0]  cc [3];
  logic signed [C-1:0]  d_r  [0:2][3];
  logic signed [EW-1:0] e1_r [0:2][3];
  logic signed [EW-1:0] e2_r [0:2][3];
  logic signed [EW-1:0] s_r  [0:2][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      oc[k] = comp(in_data.ray_origin, k);
      dc[k] = comp(in_data.ray_direction, k);
      ac[k] = comp(in_data.corner_a, k);
      bc[k] = comp(in_data.corner_b, k);
      cc[k] = comp(in_data.corner_c, k);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SUB]) begin
      for (int k = 0; k < 3; k++) begin
        d_r[0][k]  <= dc[k];
        e1_r[0][k] <= EW'(bc[k]) - EW'(ac[k]);
        e2_r[0][k] <= EW'(cc[k]) - EW'(ac[k]);
        s_r[0][k]  <= EW'(oc[k]) - EW'(ac[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products of p = dir x e2 and q = s x e1.
  // --------------------------------------------------------------------------
  logic signed [PMW-1:0] pa_r [3];
  logic signed [PMW-1:0] pb_r [3];
  logic signed [QMW-1:0] qa_r [3];
  logic signed [QMW-1:0] qb_r [3];

  always_ff @(posedge clk) begin
    if (en[S_XM]) begin
      d_r[1]  <= d_r[0];
      e1_r[1] <= e1_r[0];
      e2_r[1] <= e2_r[0];
      s_r[1]  <= s_r[0];
      pa_r[0] <= PMW'(d_r[0][1]) * PMW'(e2_r[0][2]);
      pb_r[0] <= PMW'(d_r[0][2]) * PMW'(e2_r[0][1]);
      pa_r[1] <= PMW'(d_r[0][2]) * PMW'(e2_r[0][0]);
      pb_r[1] <= PMW'(d_r[0][0]) * PMW'(e2_r[0][2]);
      pa_r[2] <= PMW'(d_r[0][0]) * PMW'(e2_r[0][1]);
      pb_r[2] <= PMW'(d_r[0][1]) * PMW'(e2_r[0][0]);
      qa_r[0] <= QMW'(s_r[0][1]) * QMW'(e1_r[0][2]);
      qb_r[0] <= QMW'(s_r[0][2]) * QMW'(e1_r[0][1]);
      qa_r[1] <= QMW'(s_r[0][2]) * QMW'(e1_r[0][0]);
      qb_r[1] <= QMW'(s_r[0][0]) * QMW'(e1_r[0][2]);
      qa_r[2] <= QMW'(s_r[0][0]) * QMW'(e1_r[0][1]);
      qb_r[2] <= QMW'(s_r[0][1]) * QMW'(e1_r[0][0]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: cross product differences.
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] p_r [3];
  logic signed [XW-1:0] q_r [3];

  always_ff @(posedge clk) begin
    if (en[S_XS]) begin
      d_r[2]  <= d_r[1];
      e1_r[2] <= e1_r[1];
      e2_r[2] <= e2_r[1];
      s_r[2]  <= s_r[1];
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= XW'(pa_r[k]) - XW'(pb_r[k]);
        q_r[k] <= XW'(qa_r[k]) - XW'(qb_r[k]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: dot product terms, each cross component split in two halves.
  // Dot 0 is det = e1.p, 1 is u = s.p, 2 is v = dir.q, 3 is t = e2.q.
  // --------------------------------------------------------------------------
  logic signed [EW-1:0]  av [4][3];
  logic signed [XW-1:0]  xv [4][3];
  logic signed [PLW-1:0] pl_r [4][3];
  logic signed [PHW-1:0] ph_r [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      av[0][k] = e1_r[2][k];
      xv[0][k] = p_r[k];
      av[1][k] = s_r[2][k];
      xv[1][k] = p_r[k];
      av[2][k] = EW'(d_r[2][k]);
      xv[2][k] = q_r[k];
      av[3][k] = e2_r[2][k];
      xv[3][k] = q_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_DM]) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          pl_r[i][k] <= PLW'(av[i][k]) * PLW'($signed({1'b0, xv[i][k][LB-1:0]}));
          ph_r[i][k] <= PHW'(av[i][k]) * PHW'($signed(xv[i][k][XW-1:LB]));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4 and 5: recombine halves, then sum the three components.
  // --------------------------------------------------------------------------
  logic signed [W-1:0] cv_r [4][3];
  logic signed [W-1:0] dv_r [4];

  always_ff @(posedge clk) begin
    if (en[S_DC]) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          cv_r[i][k] <= (W'(ph_r[i][k]) <<< LB) + W'(pl_r[i][k]);
        end
      end
    end
    if (en[S_DS]) begin
      for (int i = 0; i < 4; i++) begin
        dv_r[i] <= cv_r[i][0] + cv_r[i][1] + cv_r[i][2];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: make the determinant positive, flipping all four together.
  // Stage 7: u + v and the first set of miss tests.
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   ng_r [4];
  logic signed [W-1:0]   ck_r [4];
  logic signed [W:0]     uv_r;
  logic                  m7_r;
  logic signed [W-1:0]   thr;

  assign thr = W'($signed({1'b0, min_det_r, DET_SHIFT'(0)}));

  always_ff @(posedge clk) begin
    if (en[S_NG]) begin
      for (int i = 0; i < 4; i++) begin
        ng_r[i] <= dv_r[0][W-1] ? -dv_r[i] : dv_r[i];
      end
    end
    if (en[S_CK]) begin
      ck_r <= ng_r;
      uv_r <= (W+1)'(ng_r[1]) + (W+1)'(ng_r[2]);
      m7_r <= (ng_r[0] == '0) || (ng_r[0] < thr) || ng_r[1][W-1] ||
              (ng_r[0] < ng_r[1]) || ng_r[2][W-1] || ng_r[3][W-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8 loads the dividers; the following stages each settle one
  // quotient bit of t, u and v. Lane 0 is u, lane 1 is v, lane 2 is t.
  // --------------------------------------------------------------------------
  logic [DW-1:0] dd_r    [0:DIV_N];
  logic [DW-1:0] nn_r    [0:DIV_N][3];
  logic [DW-1:0] rr_r    [0:DIV_N][3];
  logic [QW-1:0] qq_r    [0:DIV_N][3];
  logic          sat_r   [0:DIV_N];
  logic          dmiss_r [0:DIV_N];

  always_ff @(posedge clk) begin
    if (en[S_DI]) begin
      dd_r[0]    <= ck_r[0][DW-1:0];
      sat_r[0]   <= (ck_r[3][DW-1:0] >> (Q_FRAC - 1)) >= ck_r[0][DW-1:0];
      dmiss_r[0] <= m7_r || ((W+1)'(ck_r[0]) < uv_r);
      for (int j = 0; j < 3; j++) begin
        nn_r[0][j] <= ck_r[j+1][DW-1:0];
        rr_r[0][j] <= ck_r[j+1][DW-1:0] >> (Q_FRAC - 1);
        qq_r[0][j] <= '0;
      end
    end
  end

  for (genvar g = 0; g < DIV_N; g++) begin : g_div
    localparam int K = QW - 1 - g;

    always_ff @(posedge clk) begin
      if (en[S_DI+1+g]) begin
        dd_r[g+1]    <= dd_r[g];
        sat_r[g+1]   <= sat_r[g];
        dmiss_r[g+1] <= dmiss_r[g];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic          bin;
      logic [DW:0]   rs;
      logic          ge;

      if (K >= Q_FRAC) begin : g_bit
        assign bin = nn_r[g][j][K-Q_FRAC];
      end else begin : g_zero
        assign bin = 1'b0;
      end

      assign rs = {rr_r[g][j], bin};
      assign ge = rs >= {1'b0, dd_r[g]};

      always_ff @(posedge clk) begin
        if (en[S_DI+1+g]) begin
          nn_r[g+1][j] <= nn_r[g][j];
          rr_r[g+1][j] <= ge ? DW'(rs - {1'b0, dd_r[g]}) : rs[DW-1:0];
          qq_r[g+1][j] <= {qq_r[g][j][QW-2:0], ge};
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Distance saturation, distance test and the first weight.
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0]   t_sel;
  logic [DIST_W-1:0]   t_r    [0:1];
  logic [WEIGHT_W-1:0] wa_r   [0:1];
  logic [WEIGHT_W-1:0] wb_r   [0:1];
  logic [WEIGHT_W-1:0] wc_r   [0:1];
  logic                miss_r [0:1];

  assign t_sel = sat_r[DIV_N] ? DIST_MAX : qq_r[DIV_N][2];

  always_ff @(posedge clk) begin
    if (en[S_WA]) begin
      t_r[0]    <= t_sel;
      wb_r[0]   <= qq_r[DIV_N][0][WEIGHT_W-1:0];
      wc_r[0]   <= qq_r[DIV_N][1][WEIGHT_W-1:0];
      wa_r[0]   <= WEIGHT_ONE - qq_r[DIV_N][0][WEIGHT_W-1:0] - qq_r[DIV_N][1][WEIGHT_W-1:0];
      miss_r[0] <= dmiss_r[DIV_N] || (t_sel <= DIST_W'(min_dist_r));
    end
  end

  // --------------------------------------------------------------------------
  // Normal blend: one product per corner and axis, then sum and round.
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] np_r [3][3];
  logic [FIELD_W-1:0]   nsrc [3];
  logic [WEIGHT_W-1:0]  wsrc [3];

  always_comb begin
    nsrc[0] = side_r[S_WA].normal_a;
    nsrc[1] = side_r[S_WA].normal_b;
    nsrc[2] = side_r[S_WA].normal_c;
    wsrc[0] = wa_r[0];
    wsrc[1] = wb_r[0];
    wsrc[2] = wc_r[0];
  end

  always_ff @(posedge clk) begin
    if (en[S_NM]) begin
      t_r[1]    <= t_r[0];
      wa_r[1]   <= wa_r[0];
      wb_r[1]   <= wb_r[0];
      wc_r[1]   <= wc_r[0];
      miss_r[1] <= miss_r[0];
      for (int j = 0; j < 3; j++) begin
        for (int k = 0; k < 3; k++) begin
          np_r[j][k] <= NW'(comp(nsrc[j], k)) * NW'($signed({1'b0, wsrc[j]}));
        end
      end
    end
  end

  logic signed [SW-1:0] nsum [3];
  logic signed [SW-1:0] nrnd [3];
  logic [63:0]          npack;

  always_comb begin
    npack = '0;
    for (int k = 0; k < 3; k++) begin
      nsum[k] = SW'(np_r[0][k]) + SW'(np_r[1][k]) + SW'(np_r[2][k]) + RND;
      nrnd[k] = nsum[k] >>> Q_FRAC;
      if (nrnd[k] > NHI) begin
        nrnd[k] = NHI;
      end else if (nrnd[k] < NLO) begin
        nrnd[k] = NLO;
      end
      npack[k*C +: C] = nrnd[k][C-1:0];
    end
  end

  rti_out_t out_r;

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      out_r.tag_out <= side_r[S_NM].tri_tag;
      if (miss_r[1]) begin
        out_r.hit        <= 1'b0;
        out_r.distance   <= '0;
        out_r.weight_a   <= '0;
        out_r.weight_b   <= '0;
        out_r.weight_c   <= '0;
        out_r.hit_normal <= '0;
      end else begin
        out_r.hit        <= 1'b1;
        out_r.distance   <= t_r[1];
        out_r.weight_a   <= wa_r[1];
        out_r.weight_b   <= wb_r[1];
        out_r.weight_c   <= wc_r[1];
        out_r.hit_normal <= npack[FIELD_W-1:0];
      end
    end
  end

  assign out_valid = v_r[S_OUT];
  assign out_data  = out_r;

endmodule

// ===== rtl/core/rti_sva.sv =====
// ----------------------------------------------------------------------------
// rti_sva: port-level checks of the ray/triangle intersection block
// Watches the result channel and checks the form of hit and miss beats.
// ----------------------------------------------------------------------------
module rti_sva (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input rti_pkg::rti_out_t out_data
);
  import rti_pkg::*;

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat presented after reset");

  // A stalled result beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // A miss carries only the tag.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.distance == '0 &&
      out_data.weight_a == '0 && out_data.weight_b == '0 &&
      out_data.weight_c == '0 && out_data.hit_normal == '0)
    else $error("miss beat with nonzero payload");

  // The weights of a hit add up to one.
  a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> 19'(out_data.weight_a) + 19'(out_data.weight_b) +
      19'(out_data.weight_c) == 19'(WEIGHT_ONE))
    else $error("hit weights do not sum to one");

  // A hit lies strictly ahead of the origin.
  a_hit_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.distance != '0)
    else $error("hit beat with zero distance");

endmodule

bind ray_triangle_intersect rti_sva u_rti_sva (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// tb_ray_triangle_intersect: self-checking bench for the ray/triangle test
// Streams rays and triangles into the block and predicts every result with
// an exact integer Moller-Trumbore model kept inside the bench. It walks
// through several threshold settings, varies the idling on both channels and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam int CB        = 20;
  localparam int CYCLE_CAP = 400000;
  localparam int DRAIN_GAP = 60;    // a little above the pipeline latency

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  rti_in_t in_data;
  logic out_valid;
  logic out_stall;
  rti_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ray_triangle_intersect #(.COORD_BITS(CB)) dut (.*);

  // Bench copies of the two threshold registers.
  logic [15:0] det_floor;
  logic [15:0] dist_floor;

  rti_in_t  rays_pending[$];      // items waiting to be offered
  rti_out_t hits_expected[$];     // predicted result beats, oldest first

  int idle_in_pct;
  int idle_out_pct;
  int fail_count;
  int cycle_count;
  int hold_left;
  logic hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sign-extends one packed component.
  function automatic longint comp(logic [FIELD_W-1:0] v, int k);
    logic [CB-1:0] f;
    f = v[k*CB +: CB];
    return longint'($signed(f));
  endfunction

  function automatic logic [FIELD_W-1:0] pack3(longint x, longint y, longint z);
    logic [FIELD_W-1:0] r;
    r = '0;
    r[0 +: CB]    = x[CB-1:0];
    r[CB +: CB]   = y[CB-1:0];
    r[2*CB +: CB] = z[CB-1:0];
    return r;
  endfunction

  // Exact Moller-Trumbore test: cross products use 64-bit and dot products
  // 128-bit signed values so nothing overflows; all tests but the distance
  // floor are made on the exact numerators before any division takes place.
  function automatic rti_out_t predict_intersection(rti_in_t it);
    longint o[3], d[3], a[3], e1[3], e2[3], s[3], p[3], q[3];
    longint na, nb, nc, sum, r;
    logic signed [127:0] det, un, vn, tn, thr;
    logic [127:0] quo;
    logic [30:0] t;
    logic [16:0] wa, wb, wc;
    logic [FIELD_W-1:0] nrm;
    rti_out_t res;
    res = '0;
    res.tag_out = it.tri_tag;
    for (int k = 0; k < 3; k++) begin
      o[k]  = comp(it.ray_origin, k);
      d[k]  = comp(it.ray_direction, k);
      a[k]  = comp(it.corner_a, k);
      e1[k] = comp(it.corner_b, k) - a[k];
      e2[k] = comp(it.corner_c, k) - a[k];
      s[k]  = o[k] - a[k];
    end
    p[0] = d[1]*e2[2] - d[2]*e2[1];
    p[1] = d[2]*e2[0] - d[0]*e2[2];
    p[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = 0; un = 0; vn = 0; tn = 0;
    for (int k = 0; k < 3; k++) begin
      det += 128'(signed'(e1[k])) * 128'(signed'(p[k]));
      un  += 128'(signed'(s[k]))  * 128'(signed'(p[k]));
      vn  += 128'(signed'(d[k]))  * 128'(signed'(q[k]));
      tn  += 128'(signed'(e2[k])) * 128'(signed'(q[k]));
    end
    if (det < 0) begin
      det = -det; un = -un; vn = -vn; tn = -tn;
    end
    thr = 128'(det_floor) << DET_SHIFT;
    // Parallel ray, point outside the triangle, or hit behind the origin.
    if (det == 0 || det < thr) return res;
    if (un < 0 || det < un) return res;
    if (vn < 0 || det < un + vn) return res;
    if (tn < 0) return res;
    quo = (128'(tn) << Q_FRAC) / 128'(det);
    t = (quo > 128'(DIST_MAX)) ? DIST_MAX : quo[30:0];
    // The distance saturates before it is compared with the floor.
    if (t <= 31'(dist_floor)) return res;
    quo = (128'(un) << Q_FRAC) / 128'(det);
    wb = (quo > 128'(WEIGHT_ONE)) ? WEIGHT_ONE : quo[16:0];
    quo = (128'(vn) << Q_FRAC) / 128'(det);
    wc = (quo > 128'(WEIGHT_ONE)) ? WEIGHT_ONE : quo[16:0];
    wa = WEIGHT_ONE - wb - wc;
    for (int k = 0; k < 3; k++) begin
      na = comp(it.normal_a, k);
      nb = comp(it.normal_b, k);
      nc = comp(it.normal_c, k);
      sum = na*longint'(wa) + nb*longint'(wb) + nc*longint'(wc);
      r = (sum + 64'sd32768) >>> Q_FRAC;
      if (r > (64'sd1 <<< (CB-1)) - 1) r = (64'sd1 <<< (CB-1)) - 1;
      if (r < -(64'sd1 <<< (CB-1))) r = -(64'sd1 <<< (CB-1));
      nrm[k*CB +: CB] = r[CB-1:0];
    end
    res.hit = 1'b1;
    res.distance = t;
    res.weight_a = wa;
    res.weight_b = wb;
    res.weight_c = wc;
    res.hit_normal = nrm;
    return res;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Driver: once the current beat is accepted or none is offered, the next is
  // taken from the queue unless idling; a stalled beat is held unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) hits_expected = {hits_expected, predict_intersection(in_data)};
      if (rays_pending.size() > 0 && $urandom_range(0, 99) >= idle_in_pct) begin
        in_valid <= 1'b1;
        in_data  <= rays_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks accepted result beats and drives the receiver stall,
  // including one long hold-off that lets the pipeline fill completely.
  always @(posedge clk) begin
    rti_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hits_expected.size() == 0) begin
          $error("result beat with no prediction waiting, tag %0h", out_data.tag_out);
          fail_count++;
        end else begin
          want = hits_expected.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_data.hit));
          check_field("distance", 64'(want.distance), 64'(out_data.distance));
          check_field("weight_a", 64'(want.weight_a), 64'(out_data.weight_a));
          check_field("weight_b", 64'(want.weight_b), 64'(out_data.weight_b));
          check_field("weight_c", 64'(want.weight_c), 64'(out_data.weight_c));
          check_field("hit_normal", 64'(want.hit_normal), 64'(out_data.hit_normal));
          check_field("tag_out", 64'(want.tag_out), 64'(out_data.tag_out));
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < idle_out_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb_ray_triangle_intersect failed");
      $finish;
    end
  end

  // Waits until every queued item went in and every prediction came back.
  task automatic wait_drained();
    while (rays_pending.size() > 0 || in_valid || hits_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_thresholds(logic [15:0] det_v, logic [15:0] dist_v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_MIN_DETERMINANT; cfg_wdata <= det_v;
    @(posedge clk);
    cfg_index <= CFG_MIN_DISTANCE; cfg_wdata <= dist_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    det_floor  = det_v;
    dist_floor = dist_v;
  endtask

  // Appends one item to the queue of pending items.
  task automatic add_ray(rti_in_t item);
    rays_pending = {rays_pending, item};
  endtask

  function automatic logic [FIELD_W-1:0] rand_field();
    return FIELD_W'({$urandom, $urandom});
  endfunction

  function automatic longint rand_coord(int span);
    return longint'($urandom_range(0, 2*span)) - span;
  endfunction

  // Builds a ray aimed at a chosen point of a random triangle. The direction
  // is scaled down to stretch the distance, and each component is sometimes
  // negated, which can put the triangle behind the origin.
  function automatic rti_in_t aimed_ray();
    rti_in_t it;
    longint a[3], b[3], c[3], o[3], d[3];
    int wu, wv, sh;
    wu = $urandom_range(0, 256);
    wv = $urandom_range(0, 256 - wu);
    if ($urandom_range(0, 9) == 0) wv = 256 - wu + $urandom_range(1, 40);
    sh = $urandom_range(0, 3);
    for (int k = 0; k < 3; k++) begin
      a[k] = rand_coord(65536);
      b[k] = rand_coord(65536);
      c[k] = rand_coord(65536);
      o[k] = rand_coord(131072);
      d[k] = (a[k] + ((b[k]-a[k])*wu + (c[k]-a[k])*wv) / 256 - o[k]) >>> sh;
      if ($urandom_range(0, 9) == 0) d[k] = -d[k];
    end
    it.ray_origin    = pack3(o[0], o[1], o[2]);
    it.ray_direction = pack3(d[0], d[1], d[2]);
    it.corner_a      = pack3(a[0], a[1], a[2]);
    it.corner_b      = pack3(b[0], b[1], b[2]);
    it.corner_c      = pack3(c[0], c[1], c[2]);
    it.normal_a      = rand_field();
    it.normal_b      = rand_field();
    it.normal_c      = rand_field();
    it.tri_tag       = 24'($urandom);
    return it;
  endfunction

  function automatic rti_in_t any_item();
    rti_in_t it;
    if ($urandom_range(0, 99) < 75) return aimed_ray();
    it = {rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
          rand_field(), rand_field(), rand_field(), 24'($urandom)};
    return it;
  endfunction

  task automatic queue_random(int count);
    repeat (count) add_ray(any_item());
  endtask

  // A clean unit triangle in the z=0 plane with the ray along the z axis.
  function automatic rti_in_t unit_shot(longint ox, longint oy, longint dz, logic [23:0] tag);
    rti_in_t it;
    it.ray_origin    = pack3(ox, oy, 4096);
    it.ray_direction = pack3(0, 0, dz);
    it.corner_a      = pack3(0, 0, 0);
    it.corner_b      = pack3(4096, 0, 0);
    it.corner_c      = pack3(0, 4096, 0);
    it.normal_a      = pack3(524287, -524288, 4096);
    it.normal_b      = pack3(524287, 524287, -524288);
    it.normal_c      = pack3(-524288, 0, 524287);
    it.tri_tag       = tag;
    return it;
  endfunction

  initial begin
    rti_in_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_MIN_DETERMINANT; cfg_wdata = '0;
    det_floor = 16'd1; dist_floor = 16'd1;
    idle_in_pct = 14; idle_out_pct = 62;
    fail_count = 0; cycle_count = 0; hold_req = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: zero and all-ones items, a clean hit, corner and edge
    // hits, a point outside, a hit behind the origin, a grazing parallel
    // ray and a very distant hit.
    add_ray('0);
    add_ray('1);
    add_ray(unit_shot(1024, 1024, -4096, 24'hffffff));
    add_ray(unit_shot(0, 0, -4096, 24'h000001));
    add_ray(unit_shot(4096, 0, -4096, 24'h000002));
    add_ray(unit_shot(2048, 2048, -4096, 24'h000003));
    add_ray(unit_shot(3000, 3000, -4096, 24'h000004));
    add_ray(unit_shot(-1, 100, -4096, 24'h000005));
    add_ray(unit_shot(1024, 1024, 4096, 24'h000006));
    add_ray(unit_shot(1024, 1024, 0, 24'h000007));
    add_ray(unit_shot(1024, 1024, -1, 24'h000008));
    add_ray(unit_shot(1024, 1024, -524288, 24'h000009));
    it = unit_shot(1024, 1024, -4096, 24'h00000a);
    it.ray_origin = pack3(524287, 524287, 524287);
    add_ray(it);
    it.ray_origin = pack3(-524288, -524288, -524288);
    add_ray(it);
    wait_drained();

    // Everything passes the thresholds.
    write_thresholds(16'd0, 16'd0);
    add_ray(unit_shot(1024, 1024, -524288, 24'h00000b));
    queue_random(550);
    wait_drained();

    // Strictest thresholds, with the idling swapped round.
    idle_in_pct = 62; idle_out_pct = 14;
    write_thresholds(16'hffff, 16'hffff);
    add_ray(unit_shot(1024, 1024, -4096, 24'h00000c));
    queue_random(350);
    wait_drained();

    // Random thresholds, no idling, one long receiver hold-off while the
    // sender keeps going, then a full pause of the sender.
    idle_in_pct = 0; idle_out_pct = 0;
    write_thresholds(16'($urandom_range(0, 300)), 16'($urandom_range(0, 70000)));
    queue_random(400);
    repeat (20) @(posedge clk);
    hold_req = 1'b1;
    while (hits_expected.size() > 0 || rays_pending.size() > 0 || in_valid)
      @(posedge clk);
    write_thresholds(16'd1, 16'd1);
    queue_random(420);
    wait_drained();

    if (fail_count == 0) begin
      $display("tb_ray_triangle_intersect passed");
    end else begin
      $display("tb_ray_triangle_intersect failed");
    end
    $finish;
  end

endmodule
